>>> hdl/lidar_sector_bump_avoidance_defines.svh
// Assertion macros shared by the lidar sector bump avoidance RTL.
`ifndef LIDAR_SECTOR_BUMP_AVOIDANCE_DEFINES_SVH
`define LIDAR_SECTOR_BUMP_AVOIDANCE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LSBA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define LSBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/lsba_pkg.sv
// Shared types, constants and helper functions for the lidar bump avoidance block.
package lsba_pkg;

   localparam int SectorCount          = 18;
   localparam int SecW                 = 5;
   localparam int RangeW               = 16;
   localparam int HalfW                = 4;
   localparam int KW                   = 9;
   localparam int NumW                 = 27;
   localparam int DenW                 = RangeW + KW;
   localparam int DefaultMaxScanPoints = 4096;

   localparam logic [SecW-1:0]   LastSector = SecW'(SectorCount - 1);
   localparam logic [SecW-1:0]   MirrorSector = SecW'(9);
   localparam logic [RangeW-1:0] MinStartMm = RangeW'(5800);
   localparam logic [KW-1:0]     KX = KW'(350);
   localparam logic [KW-1:0]     KY = KW'(310);
   localparam logic [KW-1:0]     KT = KW'(270);

   typedef enum logic [1:0] {
      CSR_SAFE_DISTANCE = 2'd0,
      CSR_RANGE_MIN     = 2'd1,
      CSR_RANGE_MAX     = 2'd2,
      CSR_POINTS        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic               command;
      logic [15:0]        range_mm;
      logic signed [31:0] op_vel_x;
      logic signed [31:0] op_vel_y;
      logic signed [31:0] op_vel_turn;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_vel_x;
      logic signed [31:0] out_vel_y;
      logic signed [31:0] out_vel_turn;
   } rsp_type;

   // per-sector scales in tenths
   function automatic logic [4:0] scale_x(logic [SecW-1:0] s);
      logic [4:0] v;
      unique case (s)
         5'd6, 5'd11:  v = 5'd5;
         5'd7, 5'd10:  v = 5'd10;
         5'd8, 5'd9:   v = 5'd20;
         default:      v = 5'd0;
      endcase
      return v;
   endfunction

   function automatic logic [4:0] scale_y(logic [SecW-1:0] s);
      logic [4:0] v;
      unique case (s)
         5'd0, 5'd17:  v = 5'd20;
         5'd1, 5'd16:  v = 5'd10;
         5'd2, 5'd15:  v = 5'd5;
         default:      v = 5'd0;
      endcase
      return v;
   endfunction

   function automatic logic [4:0] scale_t(logic [SecW-1:0] s);
      logic [4:0] v;
      unique case (s)
         5'd1, 5'd16:                          v = 5'd2;
         5'd2, 5'd15:                          v = 5'd5;
         5'd3, 5'd4, 5'd5, 5'd12, 5'd13, 5'd14: v = 5'd10;
         5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11:  v = 5'd20;
         default:                              v = 5'd0;
      endcase
      return v;
   endfunction

   // scale * 6553600 = (scale * 100) << 16
   function automatic logic [NumW-1:0] numer(logic [4:0] scale);
      logic [10:0] m;
      m = 11'(scale) * 11'd100;
      return {m, 16'b0};
   endfunction

   // 32-bit signed add with saturation
   function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                  logic signed [32:0] b);
      logic signed [33:0] s;
      s = 34'(a) + 34'(b);
      if (s > 34'sd2147483647) return 32'sh7FFFFFFF;
      else if (s < -34'sd2147483648) return 32'sh80000000;
      else return s[31:0];
   endfunction

endpackage

>>> hdl/lsba_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lsba_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   // shift in the next dividend bit and try the subtraction
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NUM_W);
            num_ff  <= numer;
            den_ff  <= denom;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
            num_ff <= {num_ff[NUM_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

>>> hdl/lidar_sector_bump_avoidance.sv
// A velocity word's result is registered on acceptance and shown the next cycle. A range
// sample passes through scan split, sector search and one memory read-modify-write. The last
// sample of a scan then walks all 18 sectors through read, prepare, integrate and pending-sum
// states, a near sector also through the 27-step serial divider, and the next word is taken
// only after the walk. Synchronous reset: control registers return to defaults, sector
// memories read as reset values through per-entry valid bits; no clearing pass is needed.
`include "lidar_sector_bump_avoidance_defines.svh"

module lidar_sector_bump_avoidance #(
   parameter int MAX_SCAN_POINTS = lsba_pkg::DefaultMaxScanPoints
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lsba_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lsba_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  lsba_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata
);
   import lsba_pkg::*;

   localparam int NW         = $clog2(MAX_SCAN_POINTS + 1);
   localparam int IW         = $clog2(MAX_SCAN_POINTS);
   localparam int RecipShift = NW + 5;
   localparam int Recip      = ((1 << RecipShift) + SectorCount - 1) / SectorCount;
   localparam int RecipW     = $clog2(Recip + 1);
   localparam int PW         = NW + RecipW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SPLIT, ST_HALF, ST_LOC, ST_MIN,
      ST_F_RD, ST_F_PREP, ST_F_GO, ST_F_DIV, ST_F_INT, ST_F_PEND
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [15:0] cfg_safe_ff, cfg_rmin_ff, cfg_rmax_ff;
   logic [12:0] cfg_points_ff;

   // scan bookkeeping
   logic [IW-1:0]    sample_index_ff;
   logic [NW-1:0]    n_ff, sp_ff;
   logic [HalfW-1:0] h_ff;
   logic [SecW-1:0]  sect_ff;
   logic [RangeW-1:0] smp_range_ff;

   // memories and their valid bits
   logic [RangeW-1:0] min_mem [SectorCount];
   logic [95:0]       int_mem [SectorCount];
   logic [SectorCount-1:0] min_vld_ff, int_vld_ff;
   logic [RangeW-1:0] min_rd_ff;
   logic [95:0]       int_rd_ff;
   logic              min_rdv_ff, int_rdv_ff;

   // finish path
   logic               near_ff;
   logic [DenW-1:0]    den_x_ff, den_y_ff, den_t_ff;
   logic signed [31:0] ix_ff, iy_ff, it_ff;
   logic signed [31:0] pend_x_ff, pend_y_ff, pend_t_ff;

   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                accept;
   logic [NW-1:0]       n_eff;
   logic [PW-1:0]       prod;
   logic [NW-1:0]       rem;
   logic [SecW-1:0]     sect_loc;
   logic [SecW-1:0]     min_raddr;
   logic                min_we, int_we;
   logic [RangeW-1:0]   cur_min;
   logic [RangeW-1:0]   d_safe;
   logic                div_start;
   logic                div_done;
   logic [NumW-1:0]     qx, qy, qt;
   logic signed [32:0]  qx_s, qy_s, qt_s;
   logic signed [31:0]  nx, ny, nt;
   logic                scan_end;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // clamp the scan length and take n/18 through a reciprocal
   always_comb begin
      if (int'(cfg_points_ff) < SectorCount) n_eff = NW'(SectorCount);
      else if (int'(cfg_points_ff) > MAX_SCAN_POINTS) n_eff = NW'(MAX_SCAN_POINTS);
      else n_eff = NW'(cfg_points_ff);
      prod = PW'(n_eff) * PW'(Recip);
      rem  = n_ff - NW'(sp_ff * NW'(SectorCount));
   end

   // sector of the current sample: last boundary s*sp+h not above the index
   always_comb begin
      sect_loc = '0;
      for (int s = 1; s < SectorCount; s++) begin
         if ((NW+1)'(sample_index_ff) >=
             (NW+1)'((NW+1)'(s) * (NW+1)'(sp_ff)) + (NW+1)'(h_ff))
            sect_loc = SecW'(s);
      end
   end

   assign min_raddr = (state_ff == ST_LOC) ? sect_loc : sect_ff;
   assign cur_min   = min_rdv_ff ? min_rd_ff : MinStartMm;
   assign min_we    = (state_ff == ST_MIN) && (smp_range_ff > cfg_rmin_ff) &&
                      (smp_range_ff < cfg_rmax_ff) && (smp_range_ff < cur_min);
   assign scan_end  = (NW+1)'(sample_index_ff) + (NW+1)'(1) >= (NW+1)'(n_ff);
   assign d_safe    = (cur_min == '0) ? RangeW'(1) : cur_min;
   assign div_start = (state_ff == ST_F_GO);
   assign int_we    = (state_ff == ST_F_INT);

   // new integrator values; mirrored sectors flip the sideways and turn terms
   always_comb begin
      qx_s = 33'(qx);
      qy_s = (sect_ff >= MirrorSector) ? -33'(qy) : 33'(qy);
      qt_s = (sect_ff >= MirrorSector) ? -33'(qt) : 33'(qt);
      if (near_ff) begin
         nx = sat_add(ix_ff, -qx_s);
         ny = sat_add(iy_ff, qy_s);
         nt = sat_add(it_ff, qt_s);
      end else begin
         nx = '0;
         ny = '0;
         nt = '0;
      end
   end

   // sector minimum memory
   always_ff @(posedge clock) begin
      if (min_we) min_mem[sect_ff] <= smp_range_ff;
      min_rd_ff <= min_mem[min_raddr];
   end

   // integrator memory, x / y / turn packed in one word
   always_ff @(posedge clock) begin
      if (int_we) int_mem[sect_ff] <= {nx, ny, nt};
      int_rd_ff <= int_mem[sect_ff];
   end

   // three dividers run side by side
   lsba_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div_x (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(numer(scale_x(sect_ff))), .denom(den_x_ff), .done(div_done), .quot(qx));
   lsba_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div_y (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(numer(scale_y(sect_ff))), .denom(den_y_ff), .done(), .quot(qy));
   lsba_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div_t (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(numer(scale_t(sect_ff))), .denom(den_t_ff), .done(), .quot(qt));

   // control sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cfg_safe_ff     <= 16'd500;
         cfg_rmin_ff     <= 16'd100;
         cfg_rmax_ff     <= 16'd5600;
         cfg_points_ff   <= 13'd720;
         sample_index_ff <= '0;
         min_vld_ff      <= '0;
         int_vld_ff      <= '0;
         pend_x_ff       <= '0;
         pend_y_ff       <= '0;
         pend_t_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
         sect_ff         <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SAFE_DISTANCE: cfg_safe_ff   <= csr_wdata;
               CSR_RANGE_MIN:     cfg_rmin_ff   <= csr_wdata;
               CSR_RANGE_MAX:     cfg_rmax_ff   <= csr_wdata;
               CSR_POINTS:        cfg_points_ff <= csr_wdata[12:0];
            endcase
         end

         // drop the result once taken, unless a new velocity word replaces it
         if (rsp_valid_ff && rsp_ready && !(accept && req_data.command))
            rsp_valid_ff <= 1'b0;

         min_rdv_ff <= min_vld_ff[min_raddr];
         int_rdv_ff <= int_vld_ff[sect_ff];

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_data.command) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff.out_vel_x    <= sat_add(pend_x_ff, 33'(req_data.op_vel_x));
                     rsp_data_ff.out_vel_y    <= sat_add(pend_y_ff, 33'(req_data.op_vel_y));
                     rsp_data_ff.out_vel_turn <= sat_add(pend_t_ff, 33'(req_data.op_vel_turn));
                     pend_x_ff <= '0;
                     pend_y_ff <= '0;
                     pend_t_ff <= '0;
                  end else begin
                     smp_range_ff <= req_data.range_mm;
                     state_ff     <= ST_SPLIT;
                  end
               end
            end
            ST_SPLIT: begin
               n_ff     <= n_eff;
               sp_ff    <= NW'(prod >> RecipShift);
               state_ff <= ST_HALF;
            end
            ST_HALF: begin
               h_ff     <= HalfW'(rem >> 1);
               state_ff <= ST_LOC;
            end
            ST_LOC: begin
               sect_ff  <= sect_loc;
               state_ff <= ST_MIN;
            end
            ST_MIN: begin
               if (min_we) min_vld_ff[sect_ff] <= 1'b1;
               if (scan_end) begin
                  sect_ff  <= '0;
                  state_ff <= ST_F_RD;
               end else begin
                  sample_index_ff <= sample_index_ff + 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end
            ST_F_RD: begin
               state_ff <= ST_F_PREP;
            end
            ST_F_PREP: begin
               near_ff  <= cur_min <= cfg_safe_ff;
               den_x_ff <= DenW'(d_safe) * DenW'(KX);
               den_y_ff <= DenW'(d_safe) * DenW'(KY);
               den_t_ff <= DenW'(d_safe) * DenW'(KT);
               ix_ff    <= int_rdv_ff ? int_rd_ff[95:64] : '0;
               iy_ff    <= int_rdv_ff ? int_rd_ff[63:32] : '0;
               it_ff    <= int_rdv_ff ? int_rd_ff[31:0]  : '0;
               state_ff <= (cur_min <= cfg_safe_ff) ? ST_F_GO : ST_F_INT;
            end
            ST_F_GO: begin
               state_ff <= ST_F_DIV;
            end
            ST_F_DIV: begin
               if (div_done) state_ff <= ST_F_INT;
            end
            ST_F_INT: begin
               int_vld_ff[sect_ff] <= 1'b1;
               ix_ff    <= nx;
               iy_ff    <= ny;
               it_ff    <= nt;
               state_ff <= ST_F_PEND;
            end
            ST_F_PEND: begin
               pend_x_ff <= sat_add(pend_x_ff, 33'(ix_ff));
               pend_y_ff <= sat_add(pend_y_ff, 33'(iy_ff));
               pend_t_ff <= sat_add(pend_t_ff, 33'(it_ff));
               if (sect_ff == LastSector) begin
                  min_vld_ff      <= '0;
                  sample_index_ff <= '0;
                  state_ff        <= ST_IDLE;
               end else begin
                  sect_ff  <= sect_ff + 1'b1;
                  state_ff <= ST_F_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   `LSBA_ASSERT_NEXT(a_rsp_after_cmd, clock, reset, accept && req_data.command, rsp_valid, "velocity word gave no result")
   `LSBA_ASSERT_NEXT(a_scan_clear, clock, reset, state_ff == ST_F_PEND && sect_ff == LastSector, min_vld_ff == '0 && sample_index_ff == '0, "scan end left minima or index set")
   `LSBA_ASSERT(a_sector_range, clock, reset, state_ff == ST_MIN |-> sect_ff <= LastSector, "sample mapped past last sector")

endmodule

>>> tb/tb_lidar_sector_bump_avoidance.sv
// Self-checking testbench for the lidar sector bump avoidance block.
`timescale 1ns / 100ps

module tb_lidar_sector_bump_avoidance;
   import lsba_pkg::*;

   localparam int MaxPoints = 4096;
   localparam longint CycleLimit = 3000000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_SAFE_DISTANCE;
   logic [15:0]   csr_wdata = '0;

   lidar_sector_bump_avoidance #(.MAX_SCAN_POINTS(MaxPoints)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [15:0]        safe_mm, rmin_mm, rmax_mm;
   logic [12:0]        points;
   logic [15:0]        sec_min [SectorCount];
   logic signed [31:0] int_x [SectorCount];
   logic signed [31:0] int_y [SectorCount];
   logic signed [31:0] int_t [SectorCount];
   logic signed [31:0] pend_x, pend_y, pend_t;
   int unsigned        sample_idx;

   rsp_type expected_vel [$];
   int      errors = 0;
   longint  cycles = 0;
   bit      hold_off = 1'b0;

   // per-sector scales in tenths
   int unsigned tab_x [SectorCount] = '{0,0,0,0,0,0,5,10,20,20,10,5,0,0,0,0,0,0};
   int unsigned tab_y [SectorCount] = '{20,10,5,0,0,0,0,0,0,0,0,0,0,0,0,5,10,20};
   int unsigned tab_t [SectorCount] = '{0,2,5,10,10,10,20,20,20,20,20,20,10,10,10,5,2,0};

   function automatic logic signed [31:0] clamp_add(logic signed [31:0] a, longint b);
      longint s;
      s = longint'(a) + b;
      if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (s < -64'sd2147483648) return 32'sh80000000;
      return 32'(s);
   endfunction

   function automatic longint repulsion(int unsigned sc, int unsigned d, int unsigned k);
      longint unsigned dv;
      dv = longint'(d == 0 ? 1 : d) * k;
      return longint'((longint'(sc) * 6553600) / dv);
   endfunction

   task automatic clear_avoidance();
      safe_mm = 500; rmin_mm = 100; rmax_mm = 5600; points = 720;
      for (int s = 0; s < SectorCount; s++) begin
         sec_min[s] = 16'd5800; int_x[s] = 0; int_y[s] = 0; int_t[s] = 0;
      end
      pend_x = 0; pend_y = 0; pend_t = 0; sample_idx = 0;
   endtask

   task automatic close_scan();
      longint dx, dy, dt;
      for (int s = 0; s < SectorCount; s++) begin
         if (sec_min[s] <= safe_mm) begin
            dx = repulsion(tab_x[s], sec_min[s], 350);
            dy = repulsion(tab_y[s], sec_min[s], 310);
            dt = repulsion(tab_t[s], sec_min[s], 270);
            if (s >= 9) begin
               dy = -dy; dt = -dt;
            end
            int_x[s] = clamp_add(int_x[s], -dx);
            int_y[s] = clamp_add(int_y[s], dy);
            int_t[s] = clamp_add(int_t[s], dt);
         end else begin
            int_x[s] = 0; int_y[s] = 0; int_t[s] = 0;
         end
      end
      for (int s = 0; s < SectorCount; s++) begin
         pend_x = clamp_add(pend_x, int_x[s]);
         pend_y = clamp_add(pend_y, int_y[s]);
         pend_t = clamp_add(pend_t, int_t[s]);
      end
      for (int s = 0; s < SectorCount; s++) sec_min[s] = 16'd5800;
      sample_idx = 0;
   endtask

   // predict the effect of one accepted word
   task automatic predict_avoidance(req_type w);
      int unsigned n, sp, h, sec;
      rsp_type r;
      if (w.command) begin
         r.out_vel_x = clamp_add(pend_x, longint'(w.op_vel_x));
         r.out_vel_y = clamp_add(pend_y, longint'(w.op_vel_y));
         r.out_vel_turn = clamp_add(pend_t, longint'(w.op_vel_turn));
         expected_vel.push_back(r);
         pend_x = 0; pend_y = 0; pend_t = 0;
      end else begin
         n = points;
         if (n < 18) n = 18;
         if (n > MaxPoints) n = MaxPoints;
         sp = n / 18; h = (n % 18) / 2;
         if (sample_idx < sp + h) sec = 0;
         else begin
            sec = (sample_idx - h) / sp;
            if (sec > 17) sec = 17;
         end
         if (w.range_mm > rmin_mm && w.range_mm < rmax_mm && w.range_mm < sec_min[sec])
            sec_min[sec] = w.range_mm;
         if (sample_idx + 1 >= n) close_scan();
         else sample_idx = (sample_idx + 1) & 12'hFFF;
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %s: got %08h expected %08h", what, got, want);
      errors++;
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("lidar_sector_bump_avoidance: mismatch");
         $finish;
      end
   end

   // receiver: random stalls, long hold-off when asked
   initial begin
      int gap;
      forever begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
         repeat (gap) @(posedge clock);
         while (hold_off) @(posedge clock);
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         rsp_ready <= 1'b0;
      end
   end

   // checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_vel.size() == 0) begin
            report_mismatch("unexpected word", rsp_data.out_vel_x, 32'h0);
         end else begin
            e = expected_vel.pop_front();
            if (rsp_data.out_vel_x !== e.out_vel_x)
               report_mismatch("out_vel_x", rsp_data.out_vel_x, e.out_vel_x);
            if (rsp_data.out_vel_y !== e.out_vel_y)
               report_mismatch("out_vel_y", rsp_data.out_vel_y, e.out_vel_y);
            if (rsp_data.out_vel_turn !== e.out_vel_turn)
               report_mismatch("out_vel_turn", rsp_data.out_vel_turn, e.out_vel_turn);
         end
      end
   end

   int gap_mode = 1;

   // valid is dropped only before an idle gap or a drain, so back-to-back words keep it high
   task automatic send_word(req_type w);
      int gap;
      gap = gap_mode ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_avoidance(w);
   endtask

   task automatic send_range(logic [15:0] mm);
      req_type w;
      w = '0;
      w.range_mm = mm;
      w.op_vel_x = $urandom; w.op_vel_y = $urandom; w.op_vel_turn = $urandom;
      send_word(w);
   endtask

   task automatic send_velocity(logic [31:0] vx, logic [31:0] vy, logic [31:0] vt);
      req_type w;
      w.command = 1'b1; w.range_mm = $urandom;
      w.op_vel_x = vx; w.op_vel_y = vy; w.op_vel_turn = vt;
      send_word(w);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_vel.size() != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr_valid <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SAFE_DISTANCE: safe_mm = val;
         CSR_RANGE_MIN:     rmin_mm = val;
         CSR_RANGE_MAX:     rmax_mm = val;
         default:           points = val[12:0];
      endcase
      @(posedge clock);
   endtask

   task automatic random_range();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) send_range(16'($urandom_range(0, safe_mm + 200)));
      else if (pick < 8) send_range(16'($urandom_range(rmin_mm, rmax_mm)));
      else send_range(16'($urandom));
   endtask

   task automatic random_velocity();
      logic [31:0] v [3];
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 3))
            0: v[i] = 32'h7FFFFFF0 + $urandom_range(0, 15);
            1: v[i] = 32'h80000000 + $urandom_range(0, 15);
            default: v[i] = $urandom;
         endcase
      end
      send_velocity(v[0], v[1], v[2]);
   endtask

   // directed: extremes, smallest scan, range limits, saturation
   task automatic test_directed();
      write_reg(CSR_POINTS, 16'd18);
      write_reg(CSR_SAFE_DISTANCE, 16'hFFFF);
      write_reg(CSR_RANGE_MIN, 16'd0);
      write_reg(CSR_RANGE_MAX, 16'hFFFF);
      send_range(16'd1);
      send_range(16'd0);
      send_range(16'hFFFF);
      send_range(16'hFFFE);
      for (int i = 0; i < 14; i++) send_range(16'(1 + i));
      send_velocity(32'h7FFFFFFF, 32'h80000000, 32'h00000000);
      send_velocity(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
      for (int i = 0; i < 18; i++) send_range(16'd1);
      send_velocity(32'h80000000, 32'h80000000, 32'h80000000);
      drain_results();
   endtask

   // random scans under several settings
   task automatic test_random(int words, logic [15:0] safe, logic [15:0] lo,
                              logic [15:0] hi, logic [15:0] n);
      write_reg(CSR_SAFE_DISTANCE, safe);
      write_reg(CSR_RANGE_MIN, lo);
      write_reg(CSR_RANGE_MAX, hi);
      write_reg(CSR_POINTS, n);
      for (int i = 0; i < words; i++) begin
         gap_mode = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 11) == 0) random_velocity();
         else random_range();
      end
      random_velocity();
      drain_results();
   endtask

   // receiver stalls while velocity words keep coming
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            gap_mode = 0;
            for (int i = 0; i < 30; i++) random_velocity();
         end
      join
      gap_mode = 1;
      drain_results();
   endtask

   initial begin
      clear_avoidance();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(450, 16'd500, 16'd100, 16'd5600, 16'd37);
      test_random(450, 16'd3000, 16'd0, 16'hFFFF, 16'd18);
      test_random(300, 16'd0, 16'hFFFF, 16'd0, 16'd5);
      test_random(300, 16'd40000, 16'd50, 16'd60000, 16'd100);
      test_random(400, 16'd800, 16'd10, 16'd5000, 16'h1FFF);
      test_backpressure();
      if (errors == 0 && expected_vel.size() == 0)
         $display("lidar_sector_bump_avoidance: match");
      else
         $display("lidar_sector_bump_avoidance: mismatch");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/lsba_pkg.sv
hdl/lsba_div.sv
hdl/lidar_sector_bump_avoidance.sv
tb/tb_lidar_sector_bump_avoidance.sv
